@@ sv/qgi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qgi_pkg
// Types, constants and term tables for the gyro quaternion integrator.
// ----------------------------------------------------------------------------
package qgi_pkg;

	localparam int QUAT_FRAC_BITS = 30;
	localparam int ELAPSED_BITS   = 10;
	localparam int GYRO_DIV       = 1877468;
	localparam int CFG_IDX_W      = 8;

	localparam logic [CFG_IDX_W-1:0] REG_INIT_W = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_X = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_Y = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_Z = 8'd3;

	localparam logic ACT_INTEGRATE = 1'b0;
	localparam logic ACT_LOAD      = 1'b1;

	typedef struct packed {
		logic                    action;
		logic signed [15:0]      rate_x;
		logic signed [15:0]      rate_y;
		logic signed [15:0]      rate_z;
		logic [ELAPSED_BITS-1:0] elapsed_ms;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] att_w;
		logic signed [31:0] att_x;
		logic signed [31:0] att_y;
		logic signed [31:0] att_z;
	} out_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_NORM,
		ST_SQR,
		ST_ROOT,
		ST_DIV,
		ST_FIN
	} state_t;

	// quaternion part feeding product term t (lane t[3:2], coefficient t[1:0])
	function automatic logic [1:0] term_part(input logic [3:0] t);
		logic [1:0] s;
		case (t)
			4'd0:    s = 2'd0;
			4'd1:    s = 2'd1;
			4'd2:    s = 2'd2;
			4'd3:    s = 2'd3;
			4'd4:    s = 2'd1;
			4'd5:    s = 2'd0;
			4'd6:    s = 2'd3;
			4'd7:    s = 2'd2;
			4'd8:    s = 2'd2;
			4'd9:    s = 2'd3;
			4'd10:   s = 2'd0;
			4'd11:   s = 2'd1;
			4'd12:   s = 2'd3;
			4'd13:   s = 2'd2;
			4'd14:   s = 2'd1;
			default: s = 2'd0;
		endcase
		return s;
	endfunction

	function automatic logic term_neg(input logic [3:0] t);
		logic n;
		case (t)
			4'd1, 4'd2, 4'd3, 4'd6, 4'd11, 4'd13: n = 1'b1;
			default:                              n = 1'b0;
		endcase
		return n;
	endfunction

endpackage

@@ sv/quaternion_gyro_integrator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_gyro_integrator_top
// Advances an attitude quaternion by one gyro sample and renormalises it, or loads it from the init registers.
// ----------------------------------------------------------------------------
// Sequence: a load beat goes straight to FIN and is registered at the output once it is free;
//   an integrate beat runs the bit-serial shift-add multiply, normalising shifts, squaring,
//   square root and division loops before FIN.
// Flow: one beat at a time; the next is taken the cycle after the result is queued.
// Reset: asynchronous; state and init registers return to the unit quaternion.
module quaternion_gyro_integrator_top #(
	parameter int QUAT_FRAC_BITS = qgi_pkg::QUAT_FRAC_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  qgi_pkg::in_beat_t                      in_data,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output qgi_pkg::out_beat_t                     out_data,
	input  logic                                   cfg_we,
	input  logic [qgi_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [31:0]                            cfg_data
);

	localparam int EB    = qgi_pkg::ELAPSED_BITS;
	localparam int PW    = 17 + EB;
	localparam int CW    = (16 + EB > 21) ? 16 + EB : 21;
	localparam int AW    = 34 + CW;
	localparam int MW    = AW - 1;
	localparam int NW    = 32 + QUAT_FRAC_BITS;
	localparam int CNT_W = $clog2(NW + 1);
	localparam logic [31:0] ONE_Q = 32'(64'd1 << QUAT_FRAC_BITS);

	qgi_pkg::state_t st_q, st_d;

	logic signed [31:0] init_q [4];
	logic signed [31:0] quat_q [4];
	logic signed [31:0] res_q  [4];
	logic signed [PW-1:0] p_q  [3];
	logic [MW-1:0]      mag_q  [4];
	logic [3:0]         neg_q;
	logic signed [AW-1:0] acc_q, mcand_q;
	logic [CW-1:0]      mplier_q;
	logic [63:0]        sqa_q, n_q, r_q, bit_q;
	logic [30:0]        sqb_q;
	logic [NW-1:0]      num_q;
	logic [32:0]        rem_q;
	logic [31:0]        quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [3:0]         idx_q;
	logic               out_valid_q;
	qgi_pkg::out_beat_t out_q;

	logic               in_acc, out_free;
	logic [1:0]         j;
	logic signed [31:0] qsel;
	logic               csign, tneg;
	logic [CW-1:0]      cmag;
	logic signed [PW-1:0] psel, pabs;
	logic signed [AW-1:0] acc_nx, qext;
	logic [MW-1:0]      orv;
	logic [63:0]        rb;
	logic [33:0]        remsh;
	logic               qbit;
	logic [31:0]        quo_nx;

	assign in_ready  = (st_q == qgi_pkg::ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		j      = idx_q[1:0];
		qsel   = quat_q[qgi_pkg::term_part(idx_q)];
		psel   = (j == 2'd0) ? '0 : p_q[j - 2'd1];
		pabs   = psel[PW-1] ? -psel : psel;
		csign  = (j != 2'd0) && psel[PW-1];
		cmag   = (j == 2'd0) ? CW'(qgi_pkg::GYRO_DIV) : CW'(pabs);
		tneg   = qgi_pkg::term_neg(idx_q) ^ csign;
		qext   = AW'(qsel);
		acc_nx = mplier_q[0] ? acc_q + mcand_q : acc_q;
		orv    = mag_q[0] | mag_q[1] | mag_q[2] | mag_q[3];
		rb     = r_q + bit_q;
		remsh  = {rem_q, num_q[NW-1]};
		qbit   = (remsh >= {1'b0, r_q[32:0]});
		quo_nx = {quo_q[30:0], qbit};
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			qgi_pkg::ST_IDLE: begin
				if (in_acc)
					st_d = (in_data.action == qgi_pkg::ACT_LOAD) ? qgi_pkg::ST_FIN
						: qgi_pkg::ST_MUL;
			end
			qgi_pkg::ST_MUL: begin
				if (cnt_q == CNT_W'(CW) && idx_q == 4'd15)
					st_d = qgi_pkg::ST_NORM;
			end
			qgi_pkg::ST_NORM: begin
				if (orv == '0)
					st_d = qgi_pkg::ST_FIN;
				else if (orv[MW-1:31] == '0 && orv[30])
					st_d = qgi_pkg::ST_SQR;
			end
			qgi_pkg::ST_SQR: begin
				if (cnt_q == CNT_W'(31) && idx_q[1:0] == 2'd3)
					st_d = qgi_pkg::ST_ROOT;
			end
			qgi_pkg::ST_ROOT: begin
				if (cnt_q == CNT_W'(31))
					st_d = qgi_pkg::ST_DIV;
			end
			qgi_pkg::ST_DIV: begin
				if (cnt_q == CNT_W'(NW) && idx_q[1:0] == 2'd3)
					st_d = qgi_pkg::ST_FIN;
			end
			qgi_pkg::ST_FIN: begin
				if (out_free)
					st_d = qgi_pkg::ST_IDLE;
			end
			default: st_d = qgi_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= qgi_pkg::ST_IDLE;
		else
			st_q <= st_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q      <= '{ONE_Q, 32'd0, 32'd0, 32'd0};
			quat_q      <= '{ONE_Q, 32'd0, 32'd0, 32'd0};
			res_q       <= '{default: '0};
			p_q         <= '{default: '0};
			mag_q       <= '{default: '0};
			neg_q       <= '0;
			acc_q       <= '0;
			mcand_q     <= '0;
			mplier_q    <= '0;
			sqa_q       <= '0;
			sqb_q       <= '0;
			n_q         <= '0;
			r_q         <= '0;
			bit_q       <= '0;
			num_q       <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			idx_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					qgi_pkg::REG_INIT_W: init_q[0] <= cfg_data;
					qgi_pkg::REG_INIT_X: init_q[1] <= cfg_data;
					qgi_pkg::REG_INIT_Y: init_q[2] <= cfg_data;
					qgi_pkg::REG_INIT_Z: init_q[3] <= cfg_data;
					default: ;
				endcase
			end
			if (st_q == qgi_pkg::ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (st_q)
				qgi_pkg::ST_IDLE: begin
					cnt_q <= '0;
					idx_q <= '0;
					acc_q <= '0;
					if (in_acc) begin
						res_q  <= init_q;
						p_q[0] <= PW'(in_data.rate_x * $signed({1'b0, in_data.elapsed_ms}));
						p_q[1] <= PW'(in_data.rate_y * $signed({1'b0, in_data.elapsed_ms}));
						p_q[2] <= PW'(in_data.rate_z * $signed({1'b0, in_data.elapsed_ms}));
					end
				end
				qgi_pkg::ST_MUL: begin
					if (cnt_q == '0) begin
						mcand_q  <= tneg ? -qext : qext;
						mplier_q <= cmag;
						cnt_q    <= cnt_q + 1'b1;
					end else begin
						acc_q    <= (cnt_q == CNT_W'(CW) && j == 2'd3) ? '0 : acc_nx;
						mcand_q  <= mcand_q <<< 1;
						mplier_q <= mplier_q >> 1;
						if (cnt_q == CNT_W'(CW)) begin
							cnt_q <= '0;
							idx_q <= idx_q + 1'b1;
							if (j == 2'd3) begin
								neg_q[idx_q[3:2]] <= acc_nx[AW-1];
								mag_q[idx_q[3:2]] <= MW'(acc_nx[AW-1] ? -acc_nx : acc_nx);
							end
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				qgi_pkg::ST_NORM: begin
					idx_q <= '0;
					cnt_q <= '0;
					n_q   <= '0;
					if (orv == '0) begin
						res_q <= '{32'd0, 32'd0, 32'd0, 32'd0};
					end else if (orv[MW-1:31] != '0) begin
						for (int i = 0; i < 4; i++)
							mag_q[i] <= mag_q[i] >> 1;
					end else if (!orv[30]) begin
						for (int i = 0; i < 4; i++)
							mag_q[i] <= mag_q[i] << 1;
					end
				end
				qgi_pkg::ST_SQR: begin
					if (cnt_q == '0) begin
						sqa_q <= 64'(mag_q[idx_q[1:0]][30:0]);
						sqb_q <= mag_q[idx_q[1:0]][30:0];
						cnt_q <= cnt_q + 1'b1;
					end else begin
						if (sqb_q[0])
							n_q <= n_q + sqa_q;
						sqa_q <= sqa_q << 1;
						sqb_q <= sqb_q >> 1;
						if (cnt_q == CNT_W'(31)) begin
							cnt_q <= '0;
							idx_q <= idx_q + 1'b1;
							r_q   <= '0;
							bit_q <= 64'd1 << 62;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				qgi_pkg::ST_ROOT: begin
					if (n_q >= rb) begin
						n_q <= n_q - rb;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					idx_q <= '0;
					cnt_q <= (cnt_q == CNT_W'(31)) ? '0 : cnt_q + 1'b1;
				end
				qgi_pkg::ST_DIV: begin
					if (cnt_q == '0) begin
						num_q <= ({mag_q[idx_q[1:0]][30:0], QUAT_FRAC_BITS'(0)}
							+ NW'(r_q >> 1));
						rem_q <= '0;
						quo_q <= '0;
						cnt_q <= cnt_q + 1'b1;
					end else begin
						rem_q <= qbit ? 33'(remsh - {1'b0, r_q[32:0]}) : remsh[32:0];
						quo_q <= quo_nx;
						num_q <= num_q << 1;
						if (cnt_q == CNT_W'(NW)) begin
							res_q[idx_q[1:0]] <= neg_q[idx_q[1:0]] ? -quo_nx : quo_nx;
							cnt_q <= '0;
							idx_q <= idx_q + 1'b1;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				qgi_pkg::ST_FIN: begin
					if (out_free) begin
						quat_q <= res_q;
						out_q  <= '{res_q[0], res_q[1], res_q[2], res_q[3]};
					end
				end
				default: ;
			endcase
		end
	end

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == qgi_pkg::ST_SQR |-> orv[30] && orv[MW-1:31] == '0)
		else $error("magnitudes not normalised before squaring");

	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == qgi_pkg::ST_DIV |-> r_q[63:33] == '0 && r_q[32:30] != 3'd0)
		else $error("square root out of range");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == qgi_pkg::ST_FIN))
		else $error("result raised outside finish");

endmodule
